@@ hdl/hst_pkg.sv @@
`default_nettype none
package hst_pkg;

    localparam int ESID_W   = 36;
    localparam int VSID_W   = 52;
    localparam int ATTR_W   = 4;
    localparam int SLOT_W   = 8;
    localparam int GROUP_W  = 5;
    localparam int WAY_W    = 3;
    localparam int WAYS     = 8;
    localparam int ENTRIES  = 256;

    localparam logic [SLOT_W-1:0]  GROUP_MASK   = 8'hF8;
    localparam logic [VSID_W-1:0]  DEFAULT_VSID_BIT = 52'h0001000000000;
    localparam logic [ATTR_W-1:0]  SETUP_ATTR   = 4'h4;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_MAP    = 2'd1,
        OP_SETUP  = 2'd2,
        OP_UNMAP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_NO_EVICT  = 2'd3
    } t_status;

    // payload word kept in the entry memory
    typedef struct packed {
        logic [ESID_W-1:0] esid;
        logic [VSID_W-1:0] vsid;
        logic [ATTR_W-1:0] attr;
    } t_entry;

    // result of the two group scans
    typedef struct packed {
        logic             hit;
        logic [SLOT_W-1:0] hit_slot;
        logic             pfree;
        logic [WAY_W-1:0] pfree_way;
        logic             sfree;
        logic [WAY_W-1:0] sfree_way;
        logic             ptop;
        logic [WAY_W-1:0] ptop_way;
        logic             pnb;
        logic [WAY_W-1:0] pnb_way;
        logic [WAYS-1:0]  pbolt;
    } t_scan;

endpackage
`default_nettype wire

@@ hdl/hst_flags.sv @@
`default_nettype none
// valid and bolted marks for all entries, one flop each, group read ports
module hst_flags (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [hst_pkg::GROUP_W-1:0] i_pgrp,
    output logic [hst_pkg::WAYS-1:0]        o_pval,
    output logic [hst_pkg::WAYS-1:0]        o_pbolt,
    output logic [hst_pkg::WAYS-1:0]        o_sval,
    output logic [hst_pkg::WAYS-1:0]        o_sbolt,
    input  wire logic                       i_we,
    input  wire logic [hst_pkg::SLOT_W-1:0] i_wslot,
    input  wire logic                       i_wvalid,
    input  wire logic                       i_wbolt
);
    import hst_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_bolt;
    logic [GROUP_W-1:0] sgrp;

    assign sgrp    = ~i_pgrp;
    assign o_pval  = r_valid[{i_pgrp, 3'b000} +: WAYS];
    assign o_pbolt = r_bolt[{i_pgrp, 3'b000} +: WAYS];
    assign o_sval  = r_valid[{sgrp, 3'b000} +: WAYS];
    assign o_sbolt = r_bolt[{sgrp, 3'b000} +: WAYS];

    // single-entry update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_bolt  <= '0;
        end else if (i_we) begin
            r_valid[i_wslot] <= i_wvalid;
            r_bolt[i_wslot]  <= i_wbolt;
        end
    end
endmodule
`default_nettype wire

@@ hdl/hst_mem.sv @@
`default_nettype none
// entry payload memory, one read and one write port, registered read
module hst_mem (
    input  wire logic                       i_clk,
    input  wire logic [hst_pkg::SLOT_W-1:0] i_raddr,
    output hst_pkg::t_entry                 o_rdata,
    input  wire logic                       i_we,
    input  wire logic [hst_pkg::SLOT_W-1:0] i_waddr,
    input  hst_pkg::t_entry                 i_wdata
);
    import hst_pkg::*;

    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/hashed_segment_table_core.sv @@
`default_nettype none
// hashed segment table core
// input channel i_valid/o_ready carries one request (lookup, map, bolted
// setup map, unmap); output channel o_valid/i_ready carries one result.
// the payload memory has one read port; a request reads the 8 ways of its
// primary group and then the 8 ways of its secondary group, one entry per
// cycle; after the last read lands, a decide step registers the result,
// and a map that evicts reads the victim once more before its result is
// registered. valid and bolted marks live in flip-flops and are cleared
// by reset at once, so no clearing pass is needed; entry payload is
// undefined until written.
// one request is in work at a time; the next request is taken in the
// cycle after the previous result is transferred; the result register
// holds a stalled result until i_ready rises.
// reset (synchronous, active low) drops o_valid and empties the table.
module hashed_segment_table_core #(
    parameter int SEGMENT_SHIFT = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_effective_address,
    input  wire logic [51:0] i_vsid_in,
    input  wire logic        i_use_default_vsid,
    input  wire logic        i_bolt,
    input  wire logic [3:0]  i_attributes,
    input  wire logic [2:0]  i_random_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic             o_found_existing,
    output logic [7:0]       o_slot,
    output logic [51:0]      o_vsid_out,
    output logic             o_evicted,
    output logic [35:0]      o_evicted_esid
);
    import hst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EVICT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // request registers
    logic [1:0]        r_op;
    logic [ESID_W-1:0] r_esid;
    logic [VSID_W-1:0] r_vsid;
    logic              r_bolt;
    logic [ATTR_W-1:0] r_attr;
    logic [WAY_W-1:0]  r_rnd;
    logic              r_use_def;
    logic [3:0]        r_cnt;     // read index: group bit and way
    logic              r_cnt_done;
    logic              r_rd_v;    // a read is landing this cycle
    logic [3:0]        r_rd_idx;
    logic [WAYS-1:0]   r_pmatch, r_smatch;
    logic [VSID_W-1:0] r_hit_vsid;
    logic              r_hit_seen;
    logic [SLOT_W-1:0] r_ev_slot;

    logic [GROUP_W-1:0] pgrp;
    logic [WAYS-1:0]    pval, pbolt, sval, sbolt;
    logic [SLOT_W-1:0]  raddr;
    t_entry             rdata;
    logic [ESID_W-1:0]  in_esid;
    logic [63:0]        shifted;
    logic               rd_live;

    // flag and memory write port
    logic              f_we, m_we, w_valid, w_bolt;
    logic [SLOT_W-1:0] w_slot;
    t_entry            w_data;

    // decision and result
    logic              n_ovalid;
    logic [1:0]        n_status;
    logic              n_found, n_ev;
    logic [SLOT_W-1:0] n_slot, n_ev_slot;
    logic [VSID_W-1:0] n_vout;
    logic [VSID_W-1:0] setup_vsid;
    logic              do_res;
    logic [WAY_W-1:0]  ev_way;

    assign shifted = i_effective_address >> SEGMENT_SHIFT;
    assign in_esid = shifted[ESID_W-1:0];
    assign pgrp    = r_esid[GROUP_W-1:0];
    // scan address, or the eviction victim while deciding
    assign raddr   = (r_state == S_DECIDE) ? n_ev_slot
                   : (r_cnt[3] ? {~pgrp, r_cnt[2:0]} : {pgrp, r_cnt[2:0]});
    assign rd_live = r_rd_idx[3] ? sval[r_rd_idx[2:0]] : pval[r_rd_idx[2:0]];
    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign n_ovalid = do_res;

    hst_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pgrp  (pgrp),
        .o_pval  (pval),
        .o_pbolt (pbolt),
        .o_sval  (sval),
        .o_sbolt (sbolt),
        .i_we    (f_we),
        .i_wslot (w_slot),
        .i_wvalid(w_valid),
        .i_wbolt (w_bolt)
    );

    hst_mem u_mem (
        .i_clk  (i_clk),
        .i_raddr(raddr),
        .o_rdata(rdata),
        .i_we   (m_we),
        .i_waddr(w_slot),
        .i_wdata(w_data)
    );

    // scan of the flag vectors
    t_scan sc;
    always_comb begin
        sc = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (pval[w] && r_pmatch[w]) begin
                sc.hit = 1'b1;
                sc.hit_slot = {pgrp, 3'(w)};
            end
        end
        if (!sc.hit) begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (sval[w] && r_smatch[w]) begin
                    sc.hit = 1'b1;
                    sc.hit_slot = {~pgrp, 3'(w)};
                end
            end
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!pval[w]) begin
                sc.pfree = 1'b1;
                sc.pfree_way = 3'(w);
            end
            if (!sval[w]) begin
                sc.sfree = 1'b1;
                sc.sfree_way = 3'(w);
            end
            if (!pbolt[w]) begin
                sc.pnb = 1'b1;
                sc.pnb_way = 3'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!pval[w]) begin
                sc.ptop = 1'b1;
                sc.ptop_way = 3'(w);
            end
        end
        sc.pbolt = pbolt;
    end

    assign setup_vsid = {{(VSID_W-ESID_W){1'b0}}, r_esid} | DEFAULT_VSID_BIT;
    assign ev_way     = sc.pbolt[r_rnd] ? sc.pnb_way : r_rnd;

    always_comb begin
        n_state  = r_state;
        f_we     = 1'b0;
        m_we     = 1'b0;
        w_slot   = sc.hit_slot;
        w_valid  = 1'b1;
        w_bolt   = r_bolt;
        w_data   = '{esid: r_esid, vsid: r_vsid, attr: r_attr};
        do_res   = 1'b0;
        n_status = ST_OK;
        n_found  = 1'b0;
        n_slot   = '0;
        n_vout   = '0;
        n_ev     = 1'b0;
        n_ev_slot = {pgrp, ev_way};
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_rd_v && r_rd_idx == 4'hF) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                do_res  = 1'b1;
                n_state = S_IDLE;
                n_found = sc.hit;
                case (r_op)
                    OP_LOOKUP: begin
                        if (sc.hit) begin
                            n_slot = sc.hit_slot;
                            n_vout = r_hit_vsid;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_MAP: begin
                        if (sc.hit) begin
                            n_slot = sc.hit_slot;
                            f_we = 1'b1;
                            m_we = 1'b1;
                        end else if (sc.pfree) begin
                            w_slot = {pgrp, sc.pfree_way};
                            n_slot = w_slot;
                            f_we = 1'b1;
                            m_we = 1'b1;
                        end else if (sc.sfree) begin
                            w_slot = {~pgrp, sc.sfree_way};
                            n_slot = w_slot;
                            f_we = 1'b1;
                            m_we = 1'b1;
                        end else if (sc.pnb) begin
                            // eviction needs the victim esid: read it first
                            do_res  = 1'b0;
                            n_state = S_EVICT;
                        end else begin
                            n_status = ST_NO_EVICT;
                        end
                    end
                    OP_SETUP: begin
                        if (sc.hit) begin
                            n_slot = sc.hit_slot;
                            f_we = 1'b1;
                            w_bolt = ((sc.hit_slot[SLOT_W-1:WAY_W] == pgrp)
                                   ? pbolt[sc.hit_slot[WAY_W-1:0]]
                                   : sbolt[sc.hit_slot[WAY_W-1:0]]) | r_bolt;
                        end else if (sc.ptop) begin
                            w_slot = {pgrp, sc.ptop_way};
                            n_slot = w_slot;
                            f_we = 1'b1;
                            m_we = 1'b1;
                            w_data = '{esid: r_esid,
                                       vsid: r_use_def ? setup_vsid : r_vsid,
                                       attr: SETUP_ATTR};
                        end else begin
                            n_status = ST_NO_FREE;
                        end
                    end
                    default: begin
                        if (sc.hit) begin
                            n_slot = sc.hit_slot;
                            f_we = 1'b1;
                            w_valid = 1'b0;
                            w_bolt = 1'b0;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_EVICT: begin
                if (r_rd_v) begin
                    do_res  = 1'b1;
                    n_state = S_IDLE;
                    w_slot  = r_ev_slot;
                    n_slot  = r_ev_slot;
                    f_we    = 1'b1;
                    m_we    = 1'b1;
                    n_ev    = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, scan sequencing, result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_rd_v  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_SCAN && !r_cnt_done)
                    || (r_state == S_DECIDE && n_state == S_EVICT);
            if (r_state == S_IDLE && i_valid && o_ready) begin
                r_cnt <= '0;
            end else if (r_state == S_SCAN && !r_cnt_done) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (n_ovalid) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_done <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_cnt_done <= 1'b0;
        end else if (r_state == S_SCAN && r_cnt == 4'hF && !r_cnt_done) begin
            r_cnt_done <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && o_ready) begin
            r_op       <= i_operation;
            r_esid     <= in_esid;
            r_vsid     <= i_vsid_in;
            r_bolt     <= i_bolt;
            r_attr     <= i_attributes;
            r_rnd      <= i_random_bits;
            r_use_def  <= i_use_default_vsid;
            r_pmatch   <= '0;
            r_smatch   <= '0;
            r_hit_seen <= 1'b0;
        end
        if (r_state == S_SCAN && !r_cnt_done) r_rd_idx <= r_cnt;
        if (r_state == S_SCAN && r_rd_v) begin
            if (r_rd_idx[3]) r_smatch[r_rd_idx[2:0]] <= (rdata.esid == r_esid);
            else             r_pmatch[r_rd_idx[2:0]] <= (rdata.esid == r_esid);
            // first live hit in search order supplies the lookup vsid
            if (!r_hit_seen && rd_live && rdata.esid == r_esid) begin
                r_hit_vsid <= rdata.vsid;
                r_hit_seen <= 1'b1;
            end
        end
        if (r_state == S_DECIDE) begin
            r_ev_slot <= n_ev_slot;
        end
        if (do_res) begin
            o_status         <= n_status;
            o_found_existing <= n_found;
            o_slot           <= n_slot;
            o_vsid_out       <= n_vout;
            o_evicted        <= n_ev;
            o_evicted_esid   <= n_ev ? rdata.esid : '0;
        end
    end

    // result held steady while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_status, o_found_existing,
            o_slot, o_vsid_out, o_evicted, o_evicted_esid}));

    // no request taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid));

    // a taken request closes the input
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready);

    // state register stays one-hot
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state));

    // eviction only on a successful map of a new segment
    a_evict_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> o_status == ST_OK && !o_found_existing);
endmodule
`default_nettype wire
